// ===== hw/rtl/dlle_pkg.sv =====
// shared types and constants for the doubly linked list engine
`default_nettype none

package dlle_pkg;

    localparam int KIND_W   = 3;
    localparam int HANDLE_W = 10;
    localparam int VALUE_W  = 64;
    localparam int STATUS_W = 2;

    localparam int NODES_DEFAULT = 1024;

    localparam int S_TDATA_W = ((HANDLE_W + VALUE_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((HANDLE_W + VALUE_W + HANDLE_W + 7) / 8) * 8;

    typedef enum logic [KIND_W-1:0] {
        KIND_INS_AFTER  = 3'd0,
        KIND_INS_BEFORE = 3'd1,
        KIND_ERASE      = 3'd2,
        KIND_SUCC       = 3'd3,
        KIND_PRED       = 3'd4,
        KIND_CLEAR      = 3'd5
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK   = 2'd0,
        STATUS_FULL = 2'd1,
        STATUS_BAD  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_LINK,
        ST_RESULT
    } t_state;

    typedef struct packed {
        logic accept;
        logic exec;
        logic link;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic need_link;
    } t_dp_stat;

endpackage

`default_nettype wire

// ===== hw/rtl/dlle_ctrl.sv =====
// request sequencer and output handshake for the list engine
`default_nettype none

module dlle_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    input  wire dlle_pkg::t_dp_stat i_stat,
    output dlle_pkg::t_dp_cmd       o_cmd
);

    dlle_pkg::t_state r_state;
    dlle_pkg::t_state n_state;
    logic             r_out_valid;
    logic             n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dlle_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            dlle_pkg::ST_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
                if (i_in_valid) begin
                    n_state = dlle_pkg::ST_EXEC;
                end
            end
            dlle_pkg::ST_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = i_stat.need_link ? dlle_pkg::ST_LINK : dlle_pkg::ST_RESULT;
            end
            dlle_pkg::ST_LINK: begin
                o_cmd.link = 1'b1;
                n_state    = dlle_pkg::ST_RESULT;
            end
            dlle_pkg::ST_RESULT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = dlle_pkg::ST_IDLE;
                end
            end
            default: n_state = dlle_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

// ===== hw/rtl/dlle_dp.sv =====
// node pool memories, sentinel links, counters and result registers
`default_nettype none

module dlle_dp #(
    parameter int NODES = dlle_pkg::NODES_DEFAULT
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire dlle_pkg::t_dp_cmd             i_cmd,
    input  wire logic [dlle_pkg::KIND_W-1:0]   i_kind,
    input  wire logic [dlle_pkg::HANDLE_W-1:0] i_ref_handle,
    input  wire logic [dlle_pkg::VALUE_W-1:0]  i_new_value,
    output dlle_pkg::t_dp_stat                 o_stat,
    output logic [dlle_pkg::STATUS_W-1:0]      o_status,
    output logic [dlle_pkg::HANDLE_W-1:0]      o_out_handle,
    output logic [dlle_pkg::VALUE_W-1:0]       o_out_value,
    output logic [dlle_pkg::HANDLE_W-1:0]      o_list_length
);

    localparam int HW = $clog2(NODES);
    localparam int AW = (HW > dlle_pkg::HANDLE_W) ? HW : dlle_pkg::HANDLE_W;
    localparam logic [HW:0] NODES_C = (HW + 1)'(NODES);
    localparam logic [AW:0] NODES_W = (AW + 1)'(NODES);
    localparam logic [HW:0] ALLOC_RESET = (HW + 1)'(1);

    logic [HW-1:0]                next_mem    [NODES];
    logic [HW-1:0]                prev_mem    [NODES];
    logic [dlle_pkg::VALUE_W-1:0] payload_mem [NODES];
    logic                         alive_mem   [NODES];

    logic [dlle_pkg::KIND_W-1:0]   r_kind;
    logic [dlle_pkg::HANDLE_W-1:0] r_ref_handle;
    logic [dlle_pkg::VALUE_W-1:0]  r_new_value;

    logic [HW-1:0]                r_next_rd;
    logic [HW-1:0]                r_prev_rd;
    logic                         r_alive_rd;
    logic [dlle_pkg::VALUE_W-1:0] r_pay_rd;

    logic [HW:0]   r_alloc,     n_alloc;
    logic [HW-1:0] r_live,      n_live;
    logic [HW-1:0] r_sent_next, n_sent_next;
    logic [HW-1:0] r_sent_prev, n_sent_prev;
    logic [HW-1:0] r_nb,        n_nb;
    logic [HW-1:0] r_lnk_next,  n_lnk_next;
    logic [HW-1:0] r_lnk_prev,  n_lnk_prev;

    logic [dlle_pkg::STATUS_W-1:0] r_res_status, n_res_status;
    logic [dlle_pkg::HANDLE_W-1:0] r_res_handle, n_res_handle;
    logic [dlle_pkg::VALUE_W-1:0]  r_res_value,  n_res_value;

    logic [dlle_pkg::STATUS_W-1:0] r_out_status;
    logic [dlle_pkg::HANDLE_W-1:0] r_out_handle;
    logic [dlle_pkg::VALUE_W-1:0]  r_out_value;
    logic [dlle_pkg::HANDLE_W-1:0] r_out_length;

    logic [AW-1:0] w_in_wide;
    logic [HW-1:0] w_in_addr;
    logic [AW-1:0] w_h_wide;
    logic [HW-1:0] w_h;
    logic          w_in_range;
    logic          w_is_sent;
    logic [HW-1:0] w_sel_next;
    logic [HW-1:0] w_sel_prev;
    logic          w_handle_ok;
    logic          w_full;
    logic [HW-1:0] w_new;
    logic [HW-1:0] w_nb;
    logic          w_need_link;

    logic          w_nx_we, w_pv_we, w_pay_we, w_al_we, w_al_wd;
    logic [HW-1:0] w_nx_wa, w_nx_wd, w_pv_wa, w_pv_wd, w_pay_wa, w_al_wa, w_pay_ra;

    assign w_in_wide  = AW'(i_ref_handle);
    assign w_in_addr  = w_in_wide[HW-1:0];
    assign w_h_wide   = AW'(r_ref_handle);
    assign w_h        = w_h_wide[HW-1:0];
    assign w_in_range = {1'b0, w_h_wide} < NODES_W;
    assign w_is_sent  = (r_ref_handle == '0);
    assign w_sel_next = w_is_sent ? r_sent_next : r_next_rd;
    assign w_sel_prev = w_is_sent ? r_sent_prev : r_prev_rd;
    assign w_handle_ok = w_in_range
                       && (w_is_sent || (({1'b0, w_h} < r_alloc) && r_alive_rd));
    assign w_full = (r_alloc >= NODES_C);
    assign w_new  = r_alloc[HW-1:0];
    assign w_nb   = (r_kind == dlle_pkg::KIND_SUCC) ? w_sel_next : w_sel_prev;

    always_comb begin
        n_alloc      = r_alloc;
        n_live       = r_live;
        n_sent_next  = r_sent_next;
        n_sent_prev  = r_sent_prev;
        n_nb         = r_nb;
        n_lnk_next   = r_lnk_next;
        n_lnk_prev   = r_lnk_prev;
        n_res_status = r_res_status;
        n_res_handle = r_res_handle;
        n_res_value  = r_res_value;
        w_need_link  = 1'b0;
        w_nx_we  = 1'b0;
        w_nx_wa  = '0;
        w_nx_wd  = '0;
        w_pv_we  = 1'b0;
        w_pv_wa  = '0;
        w_pv_wd  = '0;
        w_pay_we = 1'b0;
        w_pay_wa = w_new;
        w_al_we  = 1'b0;
        w_al_wa  = '0;
        w_al_wd  = 1'b0;
        w_pay_ra = w_in_addr;

        if (i_cmd.exec) begin
            w_pay_ra     = w_nb;
            n_res_status = dlle_pkg::STATUS_OK;
            n_res_handle = '0;
            n_res_value  = '0;
            if (r_kind <= dlle_pkg::KIND_PRED && !w_handle_ok) begin
                n_res_status = dlle_pkg::STATUS_BAD;
            end else begin
                unique case (r_kind) inside
                    dlle_pkg::KIND_INS_AFTER, dlle_pkg::KIND_INS_BEFORE: begin
                        if (w_full) begin
                            n_res_status = dlle_pkg::STATUS_FULL;
                        end else begin
                            w_nx_we  = 1'b1;
                            w_nx_wa  = w_new;
                            w_pv_we  = 1'b1;
                            w_pv_wa  = w_new;
                            w_pay_we = 1'b1;
                            w_al_we  = 1'b1;
                            w_al_wa  = w_new;
                            w_al_wd  = 1'b1;
                            if (r_kind == dlle_pkg::KIND_INS_AFTER) begin
                                w_nx_wd    = w_sel_next;
                                w_pv_wd    = w_h;
                                n_lnk_next = w_h;
                                n_lnk_prev = w_sel_next;
                            end else begin
                                w_nx_wd    = w_h;
                                w_pv_wd    = w_sel_prev;
                                n_lnk_next = w_sel_prev;
                                n_lnk_prev = w_h;
                            end
                            n_nb         = w_new;
                            n_alloc      = r_alloc + 1'b1;
                            n_live       = r_live + 1'b1;
                            n_res_handle = dlle_pkg::HANDLE_W'(w_new);
                            w_need_link  = 1'b1;
                        end
                    end
                    dlle_pkg::KIND_ERASE: begin
                        if (w_is_sent) begin
                            n_res_status = dlle_pkg::STATUS_BAD;
                        end else begin
                            if (w_sel_prev == '0) begin
                                n_sent_next = w_sel_next;
                            end else begin
                                w_nx_we = 1'b1;
                                w_nx_wa = w_sel_prev;
                                w_nx_wd = w_sel_next;
                            end
                            if (w_sel_next == '0) begin
                                n_sent_prev = w_sel_prev;
                            end else begin
                                w_pv_we = 1'b1;
                                w_pv_wa = w_sel_next;
                                w_pv_wd = w_sel_prev;
                            end
                            w_al_we     = 1'b1;
                            w_al_wa     = w_h;
                            w_al_wd     = 1'b0;
                            n_res_value = r_pay_rd;
                            n_live      = r_live - 1'b1;
                        end
                    end
                    dlle_pkg::KIND_SUCC, dlle_pkg::KIND_PRED: begin
                        n_nb         = w_nb;
                        n_res_handle = dlle_pkg::HANDLE_W'(w_nb);
                        w_need_link  = 1'b1;
                    end
                    dlle_pkg::KIND_CLEAR: begin
                        n_alloc     = ALLOC_RESET;
                        n_live      = '0;
                        n_sent_next = '0;
                        n_sent_prev = '0;
                    end
                    default: ;
                endcase
            end
        end

        if (i_cmd.link) begin
            if (r_kind == dlle_pkg::KIND_INS_AFTER || r_kind == dlle_pkg::KIND_INS_BEFORE) begin
                if (r_lnk_next == '0) begin
                    n_sent_next = r_nb;
                end else begin
                    w_nx_we = 1'b1;
                    w_nx_wa = r_lnk_next;
                    w_nx_wd = r_nb;
                end
                if (r_lnk_prev == '0) begin
                    n_sent_prev = r_nb;
                end else begin
                    w_pv_we = 1'b1;
                    w_pv_wa = r_lnk_prev;
                    w_pv_wd = r_nb;
                end
            end else begin
                n_res_value = (r_nb == '0) ? '0 : r_pay_rd;
            end
        end
    end

    assign o_stat.need_link = w_need_link;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alloc     <= ALLOC_RESET;
            r_live      <= '0;
            r_sent_next <= '0;
            r_sent_prev <= '0;
        end else begin
            r_alloc     <= n_alloc;
            r_live      <= n_live;
            r_sent_next <= n_sent_next;
            r_sent_prev <= n_sent_prev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_kind       <= i_kind;
            r_ref_handle <= i_ref_handle;
            r_new_value  <= i_new_value;
        end
        r_nb         <= n_nb;
        r_lnk_next   <= n_lnk_next;
        r_lnk_prev   <= n_lnk_prev;
        r_res_status <= n_res_status;
        r_res_handle <= n_res_handle;
        r_res_value  <= n_res_value;
        if (i_cmd.load_out) begin
            r_out_status <= r_res_status;
            r_out_handle <= r_res_handle;
            r_out_value  <= r_res_value;
            r_out_length <= dlle_pkg::HANDLE_W'(r_live);
        end
    end

    // link and flag reads at the referenced handle
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_next_rd  <= next_mem[w_in_addr];
            r_prev_rd  <= prev_mem[w_in_addr];
            r_alive_rd <= alive_mem[w_in_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept || i_cmd.exec) begin
            r_pay_rd <= payload_mem[w_pay_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_nx_we) begin
            next_mem[w_nx_wa] <= w_nx_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pv_we) begin
            prev_mem[w_pv_wa] <= w_pv_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pay_we) begin
            payload_mem[w_pay_wa] <= r_new_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_al_we) begin
            alive_mem[w_al_wa] <= w_al_wd;
        end
    end

    assign o_status      = r_out_status;
    assign o_out_handle  = r_out_handle;
    assign o_out_value   = r_out_value;
    assign o_list_length = r_out_length;

endmodule

`default_nettype wire

// ===== hw/rtl/doubly_linked_list_engine.sv =====
// top level of the circular doubly linked list engine with sentinel node
// the result is registered after the execute step, and after a further link step for
// successful inserts and neighbor queries
// a new request is taken only after the previous one has loaded its result, set by the
// read-then-write sequence on the single-port link memories
// a pending result that is not taken holds the request in its final step
// reset is synchronous active low; the pool is empty at once, no clearing pass
`default_nettype none

module doubly_linked_list_engine #(
    parameter int NODES = dlle_pkg::NODES_DEFAULT
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // ref_handle, new_value
    input  wire logic [dlle_pkg::S_TDATA_W-1:0] i_s_axis_tdata,
    // kind
    input  wire logic [dlle_pkg::KIND_W-1:0]    i_s_axis_tuser,
    output logic                                o_m_axis_tvalid,
    input  wire logic                           i_m_axis_tready,
    // out_handle, out_value, list_length
    output logic [dlle_pkg::M_TDATA_W-1:0]      o_m_axis_tdata,
    // status
    output logic [dlle_pkg::STATUS_W-1:0]       o_m_axis_tuser
);

    localparam int HWD = dlle_pkg::HANDLE_W;
    localparam int VW  = dlle_pkg::VALUE_W;

    dlle_pkg::t_dp_cmd  w_cmd;
    dlle_pkg::t_dp_stat w_stat;

    logic [HWD-1:0] w_out_handle;
    logic [VW-1:0]  w_out_value;
    logic [HWD-1:0] w_list_length;

    dlle_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    dlle_dp #(
        .NODES (NODES)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_kind        (i_s_axis_tuser),
        .i_ref_handle  (i_s_axis_tdata[HWD-1:0]),
        .i_new_value   (i_s_axis_tdata[HWD+VW-1:HWD]),
        .o_stat        (w_stat),
        .o_status      (o_m_axis_tuser),
        .o_out_handle  (w_out_handle),
        .o_out_value   (w_out_value),
        .o_list_length (w_list_length)
    );

    assign o_m_axis_tdata = dlle_pkg::M_TDATA_W'({w_list_length, w_out_value, w_out_handle});

`ifndef SYNTHESIS
    a_no_result_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_out |-> (!o_m_axis_tvalid || i_m_axis_tready))
        else $error("result register loaded while a result is stalled");

    a_transfer_then_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> (w_cmd.exec && !o_s_axis_tready))
        else $error("accepted request not executed in the next cycle");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tuser == dlle_pkg::STATUS_OK
                             || o_m_axis_tuser == dlle_pkg::STATUS_FULL
                             || o_m_axis_tuser == dlle_pkg::STATUS_BAD))
        else $error("undefined status code on the output");

    a_single_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones({w_cmd.accept, w_cmd.exec, w_cmd.link, w_cmd.load_out}) <= 1)
        else $error("more than one datapath step in a cycle");
`endif

endmodule

`default_nettype wire

// ===== tb/doubly_linked_list_engine_test.sv =====
// testbench for the doubly linked list engine: list requests checked against a list model
`timescale 1ns / 1ps

module doubly_linked_list_engine_test;

    localparam int KIND_W      = dlle_pkg::KIND_W;
    localparam int HANDLE_W    = dlle_pkg::HANDLE_W;
    localparam int VALUE_W     = dlle_pkg::VALUE_W;
    localparam int STATUS_W    = dlle_pkg::STATUS_W;
    localparam int S_TDATA_W   = dlle_pkg::S_TDATA_W;
    localparam int M_TDATA_W   = dlle_pkg::M_TDATA_W;
    localparam int NODES       = dlle_pkg::NODES_DEFAULT;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 12;
    localparam int RANDOM_OPS  = 520;
    localparam int TAIL_OPS    = 40;

    localparam logic [KIND_W-1:0] KIND_SPARE_6 = 3'd6;
    localparam logic [KIND_W-1:0] KIND_SPARE_7 = 3'd7;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [HANDLE_W-1:0] handle;
        logic [VALUE_W-1:0]  value;
        logic [HANDLE_W-1:0] length;
    } t_reply;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_valid = 1'b0;
    logic [S_TDATA_W-1:0] s_data = '0;
    logic [KIND_W-1:0]    s_user = '0;
    logic                 m_ready = 1'b0;
    logic                 s_ready;
    logic                 m_valid;
    logic [M_TDATA_W-1:0] m_data;
    logic [STATUS_W-1:0]  m_user;

    // list model
    logic [HANDLE_W-1:0] succ_of [NODES];
    logic [HANDLE_W-1:0] pred_of [NODES];
    logic [VALUE_W-1:0]  value_of [NODES];
    logic [NODES-1:0]    in_use;
    int                  next_handle;
    int                  live_nodes;
    logic [HANDLE_W-1:0] live_handles [$];

    t_reply replies_due [$];
    bit     quiet = 1'b0;
    int     mismatches = 0;
    int     requests_sent = 0;
    int     replies_checked = 0;
    int     deepest_list = 0;
    int     cycles = 0;

    always #1 i_clk = ~i_clk;

    doubly_linked_list_engine u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user)
    );

    function automatic void clear_list_model();
        for (int i = 0; i < NODES; i++) begin
            succ_of[i] = '0;
            pred_of[i] = '0;
        end
        in_use      = '0;
        in_use[0]   = 1'b1;
        next_handle = 1;
        live_nodes  = 0;
        live_handles.delete();
    endfunction

    function automatic t_reply apply_list_op(input logic [KIND_W-1:0] kind,
                                             input logic [HANDLE_W-1:0] h,
                                             input logic [VALUE_W-1:0] v);
        t_reply              r;
        logic [HANDLE_W-1:0] n;
        logic [HANDLE_W-1:0] nb;
        r = '0;
        if (kind <= dlle_pkg::KIND_PRED && !(int'(h) < NODES && in_use[h])) begin
            r.status = dlle_pkg::STATUS_BAD;
        end else begin
            case (kind)
                dlle_pkg::KIND_INS_AFTER, dlle_pkg::KIND_INS_BEFORE: begin
                    if (next_handle >= NODES) begin
                        r.status = dlle_pkg::STATUS_FULL;
                    end else begin
                        n = next_handle[HANDLE_W-1:0];
                        value_of[n] = v;
                        in_use[n] = 1'b1;
                        if (kind == dlle_pkg::KIND_INS_AFTER) begin
                            nb = succ_of[h];
                            succ_of[n]  = nb;
                            pred_of[n]  = h;
                            pred_of[nb] = n;
                            succ_of[h]  = n;
                        end else begin
                            nb = pred_of[h];
                            succ_of[n]  = h;
                            pred_of[n]  = nb;
                            succ_of[nb] = n;
                            pred_of[h]  = n;
                        end
                        next_handle++;
                        live_nodes++;
                        live_handles.push_back(n);
                        r.handle = n;
                    end
                end
                dlle_pkg::KIND_ERASE: begin
                    if (h == '0) begin
                        r.status = dlle_pkg::STATUS_BAD;
                    end else begin
                        nb = pred_of[h];
                        n  = succ_of[h];
                        succ_of[nb] = n;
                        pred_of[n]  = nb;
                        in_use[h] = 1'b0;
                        r.value = value_of[h];
                        live_nodes--;
                        for (int i = 0; i < live_handles.size(); i++) begin
                            if (live_handles[i] == h) begin
                                live_handles.delete(i);
                                break;
                            end
                        end
                    end
                end
                dlle_pkg::KIND_SUCC, dlle_pkg::KIND_PRED: begin
                    nb = (kind == dlle_pkg::KIND_SUCC) ? succ_of[h] : pred_of[h];
                    r.handle = nb;
                    r.value  = (nb == '0) ? '0 : value_of[nb];
                end
                dlle_pkg::KIND_CLEAR: clear_list_model();
                default: ;
            endcase
        end
        r.length = live_nodes[HANDLE_W-1:0];
        if (live_nodes > deepest_list) deepest_list = live_nodes;
        return r;
    endfunction

    function automatic logic [HANDLE_W-1:0] pick_live_handle(input bit allow_sentinel);
        if (live_handles.size() == 0 || (allow_sentinel && $urandom_range(0, 5) == 0)) begin
            return '0;
        end
        return live_handles[$urandom_range(0, live_handles.size() - 1)];
    endfunction

    function automatic logic [VALUE_W-1:0] random_value();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    function automatic logic [HANDLE_W-1:0] any_handle();
        return HANDLE_W'($urandom_range(0, NODES - 1));
    endfunction

    task automatic issue_request(input logic [KIND_W-1:0] kind, input logic [HANDLE_W-1:0] h,
                                 input logic [VALUE_W-1:0] v);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= {{(S_TDATA_W - VALUE_W - HANDLE_W){1'b0}}, v, h};
        s_user  <= kind;
        do @(posedge i_clk); while (!s_ready);
        replies_due.push_back(apply_list_op(kind, h, v));
        requests_sent++;
    endtask

    task automatic random_list_op();
        int                  pick;
        logic [KIND_W-1:0]   kind;
        logic [HANDLE_W-1:0] h;
        pick = $urandom_range(0, 99);
        if (pick < 38) begin
            kind = $urandom_range(0, 1) ? dlle_pkg::KIND_INS_AFTER : dlle_pkg::KIND_INS_BEFORE;
            issue_request(kind, pick_live_handle(1'b1), random_value());
        end else if (pick < 52) begin
            issue_request(dlle_pkg::KIND_ERASE, pick_live_handle(1'b0), random_value());
        end else if (pick < 74) begin
            kind = $urandom_range(0, 1) ? dlle_pkg::KIND_SUCC : dlle_pkg::KIND_PRED;
            issue_request(kind, pick_live_handle(1'b1), random_value());
        end else if (pick < 82) begin
            // handles up to just past the allocation point: live, freed or never allocated
            h = HANDLE_W'($urandom_range(1, (next_handle + 2 < NODES) ? next_handle + 2
                                                                      : NODES - 1));
            issue_request(KIND_W'($urandom_range(0, 4)), h, random_value());
        end else if (pick < 88) begin
            issue_request(KIND_W'($urandom_range(0, 4)), any_handle(), random_value());
        end else if (pick < 92) begin
            kind = $urandom_range(0, 1) ? KIND_SPARE_6 : KIND_SPARE_7;
            issue_request(kind, any_handle(), random_value());
        end else if (pick < 95) begin
            issue_request(dlle_pkg::KIND_ERASE, '0, random_value());
        end else if (pick < 96) begin
            issue_request(dlle_pkg::KIND_CLEAR, any_handle(), random_value());
        end else begin
            issue_request(KIND_W'($urandom_range(0, 7)), any_handle(), random_value());
        end
    endtask

    task automatic test_directed();
        issue_request(dlle_pkg::KIND_SUCC, '0, '1);
        issue_request(dlle_pkg::KIND_PRED, '0, '0);
        issue_request(dlle_pkg::KIND_ERASE, '0, '0);
        issue_request(dlle_pkg::KIND_ERASE, 10'd3, '0);
        issue_request(dlle_pkg::KIND_INS_AFTER, '0, '1);
        issue_request(dlle_pkg::KIND_INS_BEFORE, '0, '0);
        issue_request(dlle_pkg::KIND_INS_AFTER, 10'd1, 64'hA5A5_5A5A_F00D_0FF0);
        issue_request(dlle_pkg::KIND_INS_BEFORE, 10'd1023, '1);
        issue_request(dlle_pkg::KIND_SUCC, '0, '0);
        issue_request(dlle_pkg::KIND_PRED, '0, '0);
        issue_request(dlle_pkg::KIND_SUCC, 10'd2, '0);
        issue_request(dlle_pkg::KIND_PRED, 10'd1, '0);
        issue_request(KIND_SPARE_6, 10'd1023, '1);
        issue_request(KIND_SPARE_7, '0, '0);
        issue_request(dlle_pkg::KIND_ERASE, 10'd1, '0);
        issue_request(dlle_pkg::KIND_SUCC, 10'd1, '0);
        issue_request(dlle_pkg::KIND_INS_AFTER, 10'd1, '1);
        issue_request(dlle_pkg::KIND_ERASE, 10'd1, '0);
        issue_request(dlle_pkg::KIND_SUCC, '0, '0);
        issue_request(dlle_pkg::KIND_CLEAR, 10'd1023, '1);
        issue_request(dlle_pkg::KIND_SUCC, 10'd3, '0);
        issue_request(dlle_pkg::KIND_INS_AFTER, '0, 64'h5555_5555_5555_5555);
        issue_request(dlle_pkg::KIND_PRED, 10'd1, '0);
        issue_request(dlle_pkg::KIND_ERASE, 10'd1, '0);
        issue_request(dlle_pkg::KIND_SUCC, '0, '0);
    endtask

    task automatic test_random_mix();
        repeat (RANDOM_OPS) random_list_op();
    endtask

    task automatic test_back_to_back();
        logic [HANDLE_W-1:0] victim;
        quiet = 1'b1;
        issue_request(dlle_pkg::KIND_CLEAR, '0, '0);
        repeat (8) begin
            issue_request(dlle_pkg::KIND_INS_BEFORE, pick_live_handle(1'b1), random_value());
        end
        victim = pick_live_handle(1'b0);
        issue_request(dlle_pkg::KIND_ERASE, victim, '0);
        // the stale handle is rejected
        issue_request(dlle_pkg::KIND_INS_AFTER, victim, random_value());
        issue_request(dlle_pkg::KIND_SUCC, victim, '0);
        repeat (TAIL_OPS) random_list_op();
    endtask

    task automatic compare_field(input string name, input logic [VALUE_W-1:0] want,
                                 input logic [VALUE_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_reply want;
        if (i_rst_n && m_valid && m_ready) begin
            if (replies_due.size() == 0) begin
                $error("reply transfer with no request outstanding");
                mismatches++;
            end else begin
                want = replies_due.pop_front();
                compare_field("status", VALUE_W'(want.status), VALUE_W'(m_user));
                compare_field("out_handle", VALUE_W'(want.handle),
                              VALUE_W'(m_data[HANDLE_W-1:0]));
                compare_field("out_value", want.value, m_data[HANDLE_W +: VALUE_W]);
                compare_field("list_length", VALUE_W'(want.length),
                              VALUE_W'(m_data[HANDLE_W + VALUE_W +: HANDLE_W]));
                replies_checked++;
            end
        end
    end

    initial begin
        forever begin
            @(posedge i_clk);
            if (!quiet && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge i_clk);
            end
            m_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("doubly_linked_list_engine_test: errors");
            $finish;
        end
    end

    initial begin
        clear_list_model();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_mix();
        test_back_to_back();
        s_valid <= 1'b0;
        while (replies_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        $display("covered %0d requests and %0d replies: inserts, erases, neighbor queries,",
                 requests_sent, replies_checked);
        $display("bad and stale handles, spare kinds, clears, lists up to %0d nodes",
                 deepest_list);
        if (mismatches == 0 && replies_due.size() == 0) begin
            $display("doubly_linked_list_engine_test: clean");
        end else begin
            $display("doubly_linked_list_engine_test: errors");
        end
        $finish;
    end

endmodule
